/* hdl/vtf_pkg.sv */
package vtf_pkg;

  localparam int VERTEX_SLOTS_DEF = 4096;

  localparam int IDX_W  = 12;
  localparam int POS_W  = 24;
  localparam int NRM_W  = 16;
  localparam int Q_W    = 16;

  // edge = next - own, exact
  localparam int EDGE_W = POS_W + 1;
  // t1 = e x n, t2 = n x t1, exact
  localparam int T1_W   = EDGE_W + NRM_W + 1;
  localparam int T2_W   = NRM_W + T1_W + 1;
  localparam int VEC_W  = T2_W;

  // normalize unit: the largest magnitude is brought into [2^29, 2^30)
  localparam int MAG_W  = 30;
  localparam int ONE_SH = 15;

endpackage

/* hdl/vtf_corner_if.sv */
interface vtf_corner_if;
  import vtf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [POS_W-1:0] own_x;
  logic signed [POS_W-1:0] own_y;
  logic signed [POS_W-1:0] own_z;
  logic signed [POS_W-1:0] next_x;
  logic signed [POS_W-1:0] next_y;
  logic signed [POS_W-1:0] next_z;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;

  modport source (
    output valid, vertex_index, own_x, own_y, own_z, next_x, next_y, next_z,
           normal_x, normal_y, normal_z,
    input  ready
  );
  modport sink (
    input  valid, vertex_index, own_x, own_y, own_z, next_x, next_y, next_z,
           normal_x, normal_y, normal_z,
    output ready
  );
endinterface

/* hdl/vtf_frame_if.sv */
interface vtf_frame_if;
  import vtf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [IDX_W-1:0]      frame_index;
  logic signed [Q_W-1:0] tangent_x;
  logic signed [Q_W-1:0] tangent_y;
  logic signed [Q_W-1:0] tangent_z;
  logic signed [Q_W-1:0] bitangent_x;
  logic signed [Q_W-1:0] bitangent_y;
  logic signed [Q_W-1:0] bitangent_z;

  modport source (
    output valid, frame_index, tangent_x, tangent_y, tangent_z,
           bitangent_x, bitangent_y, bitangent_z,
    input  ready
  );
  modport sink (
    input  valid, frame_index, tangent_x, tangent_y, tangent_z,
           bitangent_x, bitangent_y, bitangent_z,
    output ready
  );
endinterface

/* hdl/vtf_marks.sv */
module vtf_marks #(
  parameter int SLOTS = vtf_pkg::VERTEX_SLOTS_DEF,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  output logic          busy
);
  import vtf_pkg::*;

  logic          mem [SLOTS];
  logic [AW-1:0] clr_addr;

  // clearing pass after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(SLOTS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= 1'b1;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/vtf_cross.sv */
module vtf_cross #(
  parameter int A_W = vtf_pkg::EDGE_W,
  parameter int B_W = vtf_pkg::NRM_W
) (
  input  logic                     clk,
  input  logic signed [A_W-1:0]    a [3],
  input  logic signed [B_W-1:0]    b [3],
  output logic signed [A_W+B_W:0]  r [3]
);
  import vtf_pkg::*;

  logic signed [A_W+B_W-1:0] p [6];

  // products registered, then differences registered
  always_ff @(posedge clk) begin
    p[0] <= a[1] * b[2];
    p[1] <= a[2] * b[1];
    p[2] <= a[2] * b[0];
    p[3] <= a[0] * b[2];
    p[4] <= a[0] * b[1];
    p[5] <= a[1] * b[0];
    for (int i = 0; i < 3; i++) begin
      r[i] <= (A_W+B_W+1)'(p[2*i]) - (A_W+B_W+1)'(p[2*i+1]);
    end
  end

endmodule

/* hdl/vtf_norm.sv */
module vtf_norm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [vtf_pkg::VEC_W-1:0] v [3],
  output logic                          done,
  output logic signed [vtf_pkg::Q_W-1:0]   u [3]
);
  import vtf_pkg::*;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DIV   = 3'd4;
  localparam logic [2:0] N_DONE  = 3'd5;

  localparam int NUM_W = MAG_W + ONE_SH + 1;

  logic [2:0]          state;
  logic [3:0]          cnt;
  logic                neg [3];
  logic [VEC_W-1:0]    mag [3];
  logic [VEC_W-1:0]    mx;
  logic [2*MAG_W+1:0]  acc;
  logic [63:0]         x;
  logic [63:0]         root;
  logic [63:0]         bitv;
  logic [MAG_W:0]      len;
  logic [MAG_W+1:0]    rem [3];
  logic [ONE_SH-1:0]   nb [3];
  logic [ONE_SH-1:0]   q [3];

  logic [VEC_W-1:0]    mag_in [3];
  logic [VEC_W-1:0]    mx_in;
  logic [MAG_W-1:0]    sq_sel;
  logic [2*MAG_W-1:0]  sq;
  logic [63:0]         trial;
  logic [NUM_W-1:0]    num [3];
  logic [MAG_W+1:0]    den;
  logic [MAG_W+2:0]    rem2 [3];
  logic                dge [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = v[i][VEC_W-1] ? (~v[i] + 1'b1) : v[i];
    end
    mx_in = mag_in[0];
    if (mag_in[1] > mx_in) mx_in = mag_in[1];
    if (mag_in[2] > mx_in) mx_in = mag_in[2];

    case (cnt[1:0])
      2'd0:    sq_sel = mag[0][MAG_W-1:0];
      2'd1:    sq_sel = mag[1][MAG_W-1:0];
      default: sq_sel = mag[2][MAG_W-1:0];
    endcase
    sq    = sq_sel * sq_sel;
    trial = root + bitv;

    // numerator 2^15*m + L, from the root just found
    den = {len, 1'b0};
    for (int i = 0; i < 3; i++) begin
      num[i]  = {1'b0, mag[i][MAG_W-1:0], ONE_SH'(0)} + NUM_W'(root[MAG_W:0]);
      rem2[i] = {rem[i], nb[i][ONE_SH-1]};
      dge[i]  = rem2[i] >= {1'b0, den};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        N_IDLE: begin
          if (start) begin
            state <= (mx_in == '0) ? N_DONE : N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (mx[VEC_W-1:MAG_W] == '0 && mx[MAG_W-1]) begin
            state <= N_SQ;
            cnt   <= '0;
          end
        end
        N_SQ: begin
          cnt <= cnt + 1'b1;
          if (cnt == 4'd2) begin
            state <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (bitv == '0) begin
            state <= N_DIV;
            cnt   <= '0;
          end
        end
        N_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == 4'(ONE_SH - 1)) begin
            state <= N_DONE;
          end
        end
        // a new run may start in the done cycle
        N_DONE: begin
          if (start) begin
            state <= (mx_in == '0) ? N_DONE : N_SHIFT;
          end else begin
            state <= N_IDLE;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      N_IDLE, N_DONE: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= v[i][VEC_W-1];
          mag[i] <= mag_in[i];
          q[i]   <= '0;
        end
        mx  <= mx_in;
        acc <= '0;
      end
      N_SHIFT: begin
        if (mx[VEC_W-1:MAG_W] != '0) begin
          mx <= mx >> 1;
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (!mx[MAG_W-1]) begin
          mx <= mx << 1;
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
      end
      N_SQ: begin
        acc  <= acc + (2*MAG_W+2)'(sq);
        x    <= 64'(acc + (2*MAG_W+2)'(sq));
        root <= '0;
        bitv <= 64'd1 << 62;
      end
      N_SQRT: begin
        if (bitv != '0) begin
          if (x >= trial) begin
            x    <= x - trial;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
        end else begin
          len <= root[MAG_W:0];
          for (int i = 0; i < 3; i++) begin
            rem[i] <= (MAG_W+2)'(num[i][NUM_W-1:ONE_SH]);
            nb[i]  <= num[i][ONE_SH-1:0];
          end
        end
      end
      N_DIV: begin
        for (int i = 0; i < 3; i++) begin
          rem[i] <= dge[i] ? (MAG_W+2)'(rem2[i] - {1'b0, den}) : rem2[i][MAG_W+1:0];
          nb[i]  <= nb[i] << 1;
          q[i]   <= {q[i][ONE_SH-2:0], dge[i]};
        end
      end
      default: ;
    endcase
  end

  assign done = (state == N_DONE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = neg[i] ? (Q_W'(0) - Q_W'(q[i])) : Q_W'(q[i]);
    end
  end

endmodule

/* hdl/vertex_tangent_frame.sv */
// Tangent frame per vertex from one triangle edge and the corner normal.
// Corners arrive one per transfer; the first corner seen at a vertex yields one
// frame transfer with t1 = normalize(edge x n) and t2 = normalize(n x t1), both
// Q1.14, and marks the vertex; later corners at a marked vertex, and corners
// whose index is at or beyond VERTEX_SLOTS, yield nothing. A zero-length
// vector comes out as zero. The marks sit in a one-bit-wide synchronous RAM of
// VERTEX_SLOTS entries; after reset a clearing pass over every entry
// runs before the first corner is taken. One corner is worked at a time:
// an out-of-range corner is dropped at once, an already-marked corner once
// its mark has been read, and a new vertex goes through the shared
// normalize unit, which runs twice per frame (shift, squares of the three
// components, bitwise square root, 15 divide steps and a done state each);
// a new vertex also waits while the previous frame still waits at the output.
// A finished frame waits in the output register while the next corner is
// taken.
module vertex_tangent_frame #(
  parameter int VERTEX_SLOTS = vtf_pkg::VERTEX_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  vtf_corner_if.sink   corner,
  vtf_frame_if.source  frame
);
  import vtf_pkg::*;

  localparam int AW = $clog2(VERTEX_SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_CROSS = 3'd2;
  localparam logic [2:0] S_N1    = 3'd3;
  localparam logic [2:0] S_N2    = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]               state;
  logic [1:0]               cnt;
  logic [IDX_W-1:0]         idx;
  logic [AW-1:0]            addr;
  logic signed [EDGE_W-1:0] e [3];
  logic signed [NRM_W-1:0]  n [3];
  logic signed [Q_W-1:0]    u1 [3];
  logic signed [Q_W-1:0]    u2 [3];

  logic                     clr_busy;
  logic                     mark;
  logic                     take;
  logic                     in_range;
  logic [AW-1:0]            rd_addr;
  logic                     mark_set;
  logic                     load;

  logic signed [T1_W-1:0]   t1 [3];
  logic signed [T2_W-1:0]   t2 [3];
  logic signed [VEC_W-1:0]  nrm_v [3];
  logic                     nrm_start;
  logic                     nrm_done;
  logic signed [Q_W-1:0]    nrm_u [3];

  assign corner.ready = (state == S_IDLE) && !clr_busy;
  assign take         = corner.valid && corner.ready;
  assign in_range     = 32'(corner.vertex_index) < 32'(VERTEX_SLOTS);
  assign rd_addr      = AW'(corner.vertex_index);
  // mark set once the lookup misses; the next read can't come before it lands
  assign mark_set     = (state == S_LOOK) && !mark;

  vtf_marks #(.SLOTS(VERTEX_SLOTS), .AW(AW)) u_marks (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (mark),
    .wr_en   (mark_set),
    .wr_addr (addr),
    .busy    (clr_busy)
  );

  // t1 = e x n, then t2 = n x t1; both held while the operands stay put
  vtf_cross #(.A_W(EDGE_W), .B_W(NRM_W)) u_cross_t1 (
    .clk (clk),
    .a   (e),
    .b   (n),
    .r   (t1)
  );

  vtf_cross #(.A_W(NRM_W), .B_W(T1_W)) u_cross_t2 (
    .clk (clk),
    .a   (n),
    .b   (t1),
    .r   (t2)
  );

  // one normalize unit, t1 first then t2; t2 starts in t1's done cycle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_v[i] = (state == S_CROSS) ? VEC_W'(t1[i]) : t2[i];
    end
  end
  assign nrm_start = ((state == S_CROSS) && (cnt == 2'd2)) || ((state == S_N1) && nrm_done);

  vtf_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nrm_start),
    .v     (nrm_v),
    .done  (nrm_done),
    .u     (nrm_u)
  );

  assign load = (state == S_FIN) && (!frame.valid || frame.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      frame.valid <= 1'b0;
    end else begin
      if (load) begin
        frame.valid <= 1'b1;
      end else if (frame.valid && frame.ready) begin
        frame.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take && in_range) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          cnt   <= '0;
          state <= mark ? S_IDLE : S_CROSS;
        end
        S_CROSS: begin
          cnt <= cnt + 1'b1;
          if (cnt == 2'd2) begin
            state <= S_N1;
          end
        end
        S_N1: begin
          if (nrm_done) begin
            state <= S_N2;
          end
        end
        S_N2: begin
          if (nrm_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload: corner operands, both tangents, output frame
  always_ff @(posedge clk) begin
    if (take) begin
      idx  <= corner.vertex_index;
      addr <= rd_addr;
      e[0] <= EDGE_W'(corner.next_x) - EDGE_W'(corner.own_x);
      e[1] <= EDGE_W'(corner.next_y) - EDGE_W'(corner.own_y);
      e[2] <= EDGE_W'(corner.next_z) - EDGE_W'(corner.own_z);
      n[0] <= corner.normal_x;
      n[1] <= corner.normal_y;
      n[2] <= corner.normal_z;
    end
    if (state == S_N1 && nrm_done) begin
      u1 <= nrm_u;
    end
    if (state == S_N2 && nrm_done) begin
      u2 <= nrm_u;
    end
    // payload changes only once the previous frame has left
    if (load) begin
      frame.frame_index <= idx;
      frame.tangent_x   <= u1[0];
      frame.tangent_y   <= u1[1];
      frame.tangent_z   <= u1[2];
      frame.bitangent_x <= u2[0];
      frame.bitangent_y <= u2[1];
      frame.bitangent_z <= u2[2];
    end
  end

  a_no_take_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !corner.ready)
    else $error("corner taken during mark clearing");

  a_hit_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK && mark) |=> (state == S_IDLE))
    else $error("marked vertex did not drop the corner");

  a_norm_done_owned: assert property (@(posedge clk) disable iff (rst)
    nrm_done |-> (state == S_N1 || state == S_N2))
    else $error("normalize finished outside its phase");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> frame.valid)
    else $error("finished frame not presented");

endmodule
